// ----- rtl/mwpe_pkg.sv -----
// package: shared constants, types and the gray to q8.8 conversion
`timescale 1ns / 1ps
package mwpe_pkg;

  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int MAX_SIZE   = 7;
  localparam int TAPS       = MAX_SIZE * MAX_SIZE;
  localparam int LS_ROWS    = MAX_SIZE - 1;
  localparam int GRAY_W     = 10;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 11;
  localparam int SIZE_W     = 3;
  localparam int TAP_W      = 6;
  localparam int VAL_W      = 16;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 49;
  localparam int LS_W       = LS_ROWS * GRAY_W;

  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_TAP_MASK        = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_APPEND_CONSTANT = 3'd4;

  localparam logic [VAL_W-1:0] CONST_ONE = 16'd256;

  typedef enum logic {
    FR_IDLE,
    FR_UPDATE
  } front_state_e;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_TAP,
    BK_CONST
  } back_state_e;

  // effective configuration after clamping
  typedef struct packed {
    logic [DIM_W-1:0]  width;
    logic [DIM_W-1:0]  height;
    logic [SIZE_W-1:0] size;
    logic [TAPS-1:0]   mask;
    logic              append;
  } cfg_t;

  // window entry c*MAX_SIZE+k: column c (0 newest), row k (0 current row)
  typedef logic [TAPS-1:0][GRAY_W-1:0] window_t;

  // floor(s*256/3) = 85*s + floor(s/3)
  function automatic logic [VAL_W-1:0] gray_to_q88(input logic [GRAY_W-1:0] s);
    logic [16:0] p85;
    logic [19:0] p683;
    logic [17:0] sum;
    p85  = 17'(s) * 17'd85;
    p683 = 20'(s) * 20'd683;
    sum  = 18'(p85) + 18'(p683[19:11]);
    return sum[VAL_W-1:0];
  endfunction

endpackage

// ----- rtl/mwpe_ram.sv -----
// generic single write port ram with registered read
`timescale 1ns / 1ps
module mwpe_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/mwpe_front.sv -----
// front end: pixel intake, line store, window shift and window detection
`timescale 1ns / 1ps
module mwpe_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  mwpe_pkg::cfg_t         cfg_i,
  input  logic                   pix_valid_i,
  output logic                   pix_ready_o,
  input  logic [7:0]             red_i,
  input  logic [7:0]             green_i,
  input  logic [7:0]             blue_i,
  input  logic                   q_full_i,
  output logic                   q_push_o,
  output mwpe_pkg::window_t      q_data_o
);

  mwpe_pkg::front_state_e state_q, state_d;

  logic [mwpe_pkg::COL_W-1:0]  col_cnt_q, col_cnt_d;
  logic [mwpe_pkg::ROW_W-1:0]  row_cnt_q, row_cnt_d;
  logic [mwpe_pkg::COL_W-1:0]  x_q, x_d;
  logic [mwpe_pkg::ROW_W-1:0]  y_q, y_d;
  logic [mwpe_pkg::GRAY_W-1:0] gray_q, gray_d;
  mwpe_pkg::window_t           win_q, win_d;

  logic                        accept;
  logic [mwpe_pkg::COL_W-1:0]  x_cur;
  logic [mwpe_pkg::ROW_W-1:0]  y_cur;
  logic [mwpe_pkg::DIM_W-1:0]  x_inc;
  logic [mwpe_pkg::DIM_W-1:0]  y_inc;
  logic                        ls_we;
  logic [mwpe_pkg::LS_W-1:0]   ls_rdata;
  logic [mwpe_pkg::LS_W-1:0]   ls_wdata;
  logic [11:0]                 xe, ye, we12, he12, sz12, h12;
  logic                        in_frame;

  assign pix_ready_o = (state_q == mwpe_pkg::FR_IDLE) && !q_full_i;
  assign accept      = pix_valid_i && pix_ready_o;

  // wrap a position left past the frame by a register change
  assign x_cur = (mwpe_pkg::DIM_W'(col_cnt_q) >= cfg_i.width) ? '0 : col_cnt_q;
  assign y_cur = (mwpe_pkg::DIM_W'(row_cnt_q) >= cfg_i.height) ? '0 : row_cnt_q;
  assign x_inc = mwpe_pkg::DIM_W'(x_cur) + 11'd1;
  assign y_inc = mwpe_pkg::DIM_W'(y_cur) + 11'd1;

  assign ls_wdata = {ls_rdata[mwpe_pkg::LS_W-mwpe_pkg::GRAY_W-1:0], gray_q};

  mwpe_ram #(
    .WIDTH(mwpe_pkg::LS_W),
    .DEPTH(mwpe_pkg::MAX_WIDTH)
  ) u_line_store (
    .clk_i  (clk_i),
    .we_i   (ls_we),
    .waddr_i(x_q),
    .wdata_i(ls_wdata),
    .re_i   (accept),
    .raddr_i(x_cur),
    .rdata_o(ls_rdata)
  );

  assign xe   = 12'(x_q);
  assign ye   = 12'(y_q);
  assign we12 = 12'(cfg_i.width);
  assign he12 = 12'(cfg_i.height);
  assign sz12 = 12'(cfg_i.size);
  assign h12  = 12'(cfg_i.size >> 1);

  assign in_frame = (xe + 12'd1 >= sz12) && (ye + 12'd1 >= sz12) &&
                    (xe + (h12 << 1) + 12'd1 <= we12 - 12'd1 + sz12) &&
                    (ye + (h12 << 1) + 12'd1 <= he12 - 12'd1 + sz12);

  always_comb begin
    state_d   = state_q;
    col_cnt_d = col_cnt_q;
    row_cnt_d = row_cnt_q;
    x_d       = x_q;
    y_d       = y_q;
    gray_d    = gray_q;
    win_d     = win_q;
    ls_we     = 1'b0;
    q_push_o  = 1'b0;
    unique case (state_q)
      mwpe_pkg::FR_IDLE: begin
        if (accept) begin
          x_d    = x_cur;
          y_d    = y_cur;
          gray_d = mwpe_pkg::GRAY_W'(red_i) + mwpe_pkg::GRAY_W'(green_i) +
                   mwpe_pkg::GRAY_W'(blue_i);
          if (x_inc >= cfg_i.width) begin
            col_cnt_d = '0;
            row_cnt_d = (y_inc >= cfg_i.height) ? '0 : y_inc[mwpe_pkg::ROW_W-1:0];
          end else begin
            col_cnt_d = x_inc[mwpe_pkg::COL_W-1:0];
            row_cnt_d = y_cur;
          end
          state_d = mwpe_pkg::FR_UPDATE;
        end
      end
      mwpe_pkg::FR_UPDATE: begin
        ls_we = 1'b1;
        for (int c = mwpe_pkg::MAX_SIZE - 1; c >= 1; c--) begin
          for (int k = 0; k < mwpe_pkg::MAX_SIZE; k++) begin
            win_d[c * mwpe_pkg::MAX_SIZE + k] = win_q[(c - 1) * mwpe_pkg::MAX_SIZE + k];
          end
        end
        win_d[0] = gray_q;
        for (int k = 1; k < mwpe_pkg::MAX_SIZE; k++) begin
          win_d[k] = ls_rdata[(k - 1) * mwpe_pkg::GRAY_W +: mwpe_pkg::GRAY_W];
        end
        q_push_o = in_frame && ((cfg_i.mask != '0) || cfg_i.append);
        state_d  = mwpe_pkg::FR_IDLE;
      end
      default: state_d = mwpe_pkg::FR_IDLE;
    endcase
  end

  assign q_data_o = win_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= mwpe_pkg::FR_IDLE;
      col_cnt_q <= '0;
      row_cnt_q <= '0;
    end else begin
      state_q   <= state_d;
      col_cnt_q <= col_cnt_d;
      row_cnt_q <= row_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q    <= x_d;
    y_q    <= y_d;
    gray_q <= gray_d;
    win_q  <= win_d;
  end

endmodule

// ----- rtl/mwpe_queue.sv -----
// two-entry queue of window snapshots between front and back
`timescale 1ns / 1ps
module mwpe_queue (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  mwpe_pkg::window_t push_data_i,
  input  logic              pop_i,
  output logic              full_o,
  output logic              empty_o,
  output mwpe_pkg::window_t head_o
);

  mwpe_pkg::window_t entry_q [2];
  logic              wr_ptr_q, wr_ptr_d;
  logic              rd_ptr_q, rd_ptr_d;
  logic [1:0]        count_q, count_d;

  assign full_o  = (count_q == 2'd2);
  assign empty_o = (count_q == 2'd0);
  assign head_o  = entry_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push_i ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop_i ? ~rd_ptr_q : rd_ptr_q;
    count_d  = count_q + 2'(push_i) - 2'(pop_i);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

// ----- rtl/mwpe_back.sv -----
// back end: walks the window taps and drives the output register
`timescale 1ns / 1ps
module mwpe_back (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  mwpe_pkg::cfg_t                cfg_i,
  input  logic                          q_empty_i,
  input  mwpe_pkg::window_t             q_head_i,
  output logic                          q_pop_o,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [mwpe_pkg::VAL_W-1:0]    sample_value_o,
  output logic [mwpe_pkg::TAP_W-1:0]    column_index_o,
  output logic                          is_constant_o,
  output logic                          last_of_window_o
);

  mwpe_pkg::back_state_e state_q, state_d;

  logic [mwpe_pkg::TAP_W-1:0]  bit_q, bit_d;
  logic [mwpe_pkg::SIZE_W-1:0] ci_q, ci_d;
  logic [mwpe_pkg::SIZE_W-1:0] rk_q, rk_d;
  logic [mwpe_pkg::TAP_W-1:0]  n_q, n_d;

  logic                        valid_q, valid_d;
  logic [mwpe_pkg::VAL_W-1:0]  value_q, value_d;
  logic [mwpe_pkg::TAP_W-1:0]  colidx_q, colidx_d;
  logic                        const_q, const_d;
  logic                        last_q, last_d;

  logic                        out_free;
  logic                        sel;
  logic [mwpe_pkg::TAP_W-1:0]  tap_idx;
  logic [mwpe_pkg::TAPS-1:0]   mask_hi;
  logic                        walk_done;

  assign out_free  = !valid_q || out_ready_i;
  assign sel       = cfg_i.mask[bit_q];
  assign tap_idx   = mwpe_pkg::TAP_W'(ci_q) * mwpe_pkg::TAP_W'(mwpe_pkg::MAX_SIZE) +
                     mwpe_pkg::TAP_W'(rk_q);
  assign mask_hi   = cfg_i.mask >> bit_q;
  assign walk_done = (ci_q == '0) && (rk_q == '0);

  always_comb begin
    state_d  = state_q;
    bit_d    = bit_q;
    ci_d     = ci_q;
    rk_d     = rk_q;
    n_d      = n_q;
    valid_d  = valid_q && !out_ready_i;
    value_d  = value_q;
    colidx_d = colidx_q;
    const_d  = const_q;
    last_d   = last_q;
    q_pop_o  = 1'b0;
    unique case (state_q)
      mwpe_pkg::BK_IDLE: begin
        if (!q_empty_i) begin
          bit_d   = '0;
          ci_d    = cfg_i.size - 3'd1;
          rk_d    = cfg_i.size - 3'd1;
          n_d     = '0;
          state_d = mwpe_pkg::BK_TAP;
        end
      end
      mwpe_pkg::BK_TAP: begin
        if (!sel || out_free) begin
          if (sel) begin
            valid_d  = 1'b1;
            value_d  = mwpe_pkg::gray_to_q88(q_head_i[tap_idx]);
            colidx_d = n_q;
            const_d  = 1'b0;
            last_d   = (mask_hi[mwpe_pkg::TAPS-1:1] == '0) && !cfg_i.append;
            n_d      = n_q + 6'd1;
          end
          bit_d = bit_q + 6'd1;
          if (walk_done) begin
            if (cfg_i.append) begin
              state_d = mwpe_pkg::BK_CONST;
            end else begin
              q_pop_o = 1'b1;
              state_d = mwpe_pkg::BK_IDLE;
            end
          end else if (rk_q == '0) begin
            ci_d = ci_q - 3'd1;
            rk_d = cfg_i.size - 3'd1;
          end else begin
            rk_d = rk_q - 3'd1;
          end
        end
      end
      mwpe_pkg::BK_CONST: begin
        if (out_free) begin
          valid_d  = 1'b1;
          value_d  = mwpe_pkg::CONST_ONE;
          colidx_d = n_q;
          const_d  = 1'b1;
          last_d   = 1'b1;
          q_pop_o  = 1'b1;
          state_d  = mwpe_pkg::BK_IDLE;
        end
      end
      default: state_d = mwpe_pkg::BK_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= mwpe_pkg::BK_IDLE;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bit_q    <= bit_d;
    ci_q     <= ci_d;
    rk_q     <= rk_d;
    n_q      <= n_d;
    value_q  <= value_d;
    colidx_q <= colidx_d;
    const_q  <= const_d;
    last_q   <= last_d;
  end

  assign out_valid_o      = valid_q;
  assign sample_value_o   = value_q;
  assign column_index_o   = colidx_q;
  assign is_constant_o    = const_q;
  assign last_of_window_o = last_q;

endmodule

// ----- rtl/masked_window_patch_expander.sv -----
// top level: masked sliding window patch expander
//
// slave stream takes one rgb pixel per beat in raster order; the master
// stream gives, for each window wholly inside the frame (at an even size
// not one ending in the last column or row), one beat per tap selected by
// tap_mask (gray in unsigned q8.8) and then, if enabled, the constant 1.0
// with tuser set; tlast marks the last beat of a window. registers are
// written through cfg_we_i / cfg_index_i / cfg_data_i; the user must do so
// only while the block is idle, as the block itself does not enforce it.
// the front end takes a pixel only while idle and the queue is not full,
// and finishes it (line store read, then write back and window shift)
// before taking the next. a completed window goes through a two-entry
// queue to the back end, which picks it up from idle, walks all size*size
// window positions at one per cycle (a selected tap waits on a held output
// register) and then, if enabled, sends the constant.
// reset returns registers to 640x480, size 3, mask 511, constant on, and
// the position to the first pixel; line store contents are undefined until
// written by the first rows of a frame. a stalled master side holds the
// output register, the back end then waits, the queue fills and tready drops.
`timescale 1ns / 1ps
module masked_window_patch_expander (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [mwpe_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [mwpe_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  input  logic [23:0]                         s_axis_tdata,   // red, green, blue
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  output logic [23:0]                         m_axis_tdata,   // sample_value, column_index, pad
  output logic                                m_axis_tlast,
  output logic                                m_axis_tuser    // is_constant
);

  logic [mwpe_pkg::DIM_W-1:0]  width_q;
  logic [mwpe_pkg::DIM_W-1:0]  height_q;
  logic [mwpe_pkg::SIZE_W-1:0] size_q;
  logic [mwpe_pkg::TAPS-1:0]   mask_q;
  logic                        append_q;

  mwpe_pkg::cfg_t              cfg;
  logic [mwpe_pkg::TAP_W-1:0]  size_sq;
  logic [mwpe_pkg::TAPS-1:0]   mask_lim;

  logic                        q_full;
  logic                        q_empty;
  logic                        q_push;
  logic                        q_pop;
  mwpe_pkg::window_t           q_wdata;
  mwpe_pkg::window_t           q_head;

  logic [mwpe_pkg::VAL_W-1:0]  sample_value;
  logic [mwpe_pkg::TAP_W-1:0]  column_index;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd640;
      height_q <= 11'd480;
      size_q   <= 3'd3;
      mask_q   <= 49'd511;
      append_q <= 1'b1;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        mwpe_pkg::CFG_IMAGE_WIDTH:     width_q  <= cfg_data_i[mwpe_pkg::DIM_W-1:0];
        mwpe_pkg::CFG_IMAGE_HEIGHT:    height_q <= cfg_data_i[mwpe_pkg::DIM_W-1:0];
        mwpe_pkg::CFG_WINDOW_SIZE:     size_q   <= cfg_data_i[mwpe_pkg::SIZE_W-1:0];
        mwpe_pkg::CFG_TAP_MASK:        mask_q   <= cfg_data_i[mwpe_pkg::TAPS-1:0];
        mwpe_pkg::CFG_APPEND_CONSTANT: append_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // clamp to the supported range, zero counts as one
  always_comb begin
    cfg.width  = (width_q == '0) ? 11'd1 :
                 (width_q > mwpe_pkg::DIM_W'(mwpe_pkg::MAX_WIDTH)) ?
                 mwpe_pkg::DIM_W'(mwpe_pkg::MAX_WIDTH) : width_q;
    cfg.height = (height_q == '0) ? 11'd1 :
                 (height_q > mwpe_pkg::DIM_W'(mwpe_pkg::MAX_HEIGHT)) ?
                 mwpe_pkg::DIM_W'(mwpe_pkg::MAX_HEIGHT) : height_q;
    cfg.size   = (size_q == '0) ? 3'd1 : size_q;
    size_sq    = mwpe_pkg::TAP_W'(cfg.size) * mwpe_pkg::TAP_W'(cfg.size);
    mask_lim   = ~({mwpe_pkg::TAPS{1'b1}} << size_sq);
    cfg.mask   = mask_q & mask_lim;
    cfg.append = append_q;
  end

  mwpe_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .pix_valid_i(s_axis_tvalid),
    .pix_ready_o(s_axis_tready),
    .red_i      (s_axis_tdata[7:0]),
    .green_i    (s_axis_tdata[15:8]),
    .blue_i     (s_axis_tdata[23:16]),
    .q_full_i   (q_full),
    .q_push_o   (q_push),
    .q_data_o   (q_wdata)
  );

  mwpe_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (q_push),
    .push_data_i(q_wdata),
    .pop_i      (q_pop),
    .full_o     (q_full),
    .empty_o    (q_empty),
    .head_o     (q_head)
  );

  mwpe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .q_empty_i       (q_empty),
    .q_head_i        (q_head),
    .q_pop_o         (q_pop),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .sample_value_o  (sample_value),
    .column_index_o  (column_index),
    .is_constant_o   (m_axis_tuser),
    .last_of_window_o(m_axis_tlast)
  );

  assign m_axis_tdata = {2'b00, column_index, sample_value};

endmodule

// ----- dv/testbench.sv -----
// self-checking testbench for the masked window patch expander
`timescale 1ns / 1ps
module testbench;
  import mwpe_pkg::*;

  localparam int unsigned SETTLE_CYCLES  = 150;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RANDOM_PIXELS  = 300;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
  } pixel_t;

  typedef struct packed {
    logic [15:0] sample_value;
    logic [5:0]  column_index;
    logic        is_constant;
    logic        last_of_window;
  } sample_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  cfg_we_i = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [23:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [23:0]           m_axis_tdata;
  logic                  m_axis_tlast;
  logic                  m_axis_tuser;

  masked_window_patch_expander DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),   // red, green, blue
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),   // sample_value, column_index, pad
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)    // is_constant
  );

  always #6 clk_i = ~clk_i;

  // predictor copy of registers and pixel history
  logic [10:0]   reg_width;
  logic [10:0]   reg_height;
  logic [2:0]    reg_size;
  logic [48:0]   reg_mask;
  logic          reg_append;
  logic [9:0]    row_history [6][1024];
  logic [9:0]    window_taps [7][7];
  int unsigned   col_pos;
  int unsigned   row_pos;

  sample_t       expected_samples [$];
  sample_t       head;
  int unsigned   mismatches = 0;
  int unsigned   gap_pct = 0;
  int unsigned   stall_pct = 0;
  int            stall_left = 0;
  int unsigned   quiet_cycles = 0;

  function automatic int unsigned clamp_dim(input int unsigned v, input int unsigned hi);
    if (v == 0) return 1;
    if (v > hi) return hi;
    return v;
  endfunction

  function automatic logic [7:0] rand_channel();
    case ($urandom_range(7))
      0: return 8'd0;
      1: return 8'd255;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  function automatic pixel_t rand_pixel();
    pixel_t px;
    px.red   = rand_channel();
    px.green = rand_channel();
    px.blue  = rand_channel();
    return px;
  endfunction

  function automatic logic [48:0] rand_mask();
    logic [63:0] bits;
    bits = {$urandom(), $urandom()};
    return bits[48:0];
  endfunction

  function automatic int unsigned pick_idle_pct();
    case ($urandom_range(2))
      0: return 0;
      1: return 15;
      default: return 40;
    endcase
  endfunction

  // gray sums through line history and window, then the selected taps
  task automatic expand_pixel(input pixel_t px);
    int unsigned w, hgt, sz, half, x, y, total, n, k, c, i, j, q;
    logic [9:0]  gray;
    logic [9:0]  column [7];
    sample_t     s;
    w    = clamp_dim(reg_width, MAX_WIDTH);
    hgt  = clamp_dim(reg_height, MAX_HEIGHT);
    sz   = clamp_dim(reg_size, MAX_SIZE);
    half = sz / 2;
    gray = 10'(px.red) + 10'(px.green) + 10'(px.blue);
    if (col_pos >= w) col_pos = 0;
    if (row_pos >= hgt) row_pos = 0;
    x = col_pos;
    y = row_pos;
    column[0] = gray;
    for (k = 1; k < 7; k++) column[k] = row_history[k-1][x];
    for (k = 5; k >= 1; k--) row_history[k][x] = row_history[k-1][x];
    row_history[0][x] = gray;
    for (c = 6; c >= 1; c--) begin
      for (k = 0; k < 7; k++) window_taps[c][k] = window_taps[c-1][k];
    end
    for (k = 0; k < 7; k++) window_taps[0][k] = column[k];
    if (x + 1 >= sz && y + 1 >= sz &&
        x + 2 * half + 1 <= w - 1 + sz && y + 2 * half + 1 <= hgt - 1 + sz) begin
      total = reg_append;
      for (k = 0; k < sz * sz; k++) total += reg_mask[k];
      n = 0;
      for (i = 0; i < sz; i++) begin
        for (j = 0; j < sz; j++) begin
          if (reg_mask[i * sz + j]) begin
            q = (int'(window_taps[sz-1-i][sz-1-j]) * 256) / 3;
            s.sample_value   = q[15:0];
            s.column_index   = 6'(n);
            s.is_constant    = 1'b0;
            s.last_of_window = (n == total - 1);
            expected_samples.push_back(s);
            n++;
          end
        end
      end
      if (reg_append) begin
        s.sample_value   = CONST_ONE;
        s.column_index   = 6'(n);
        s.is_constant    = 1'b1;
        s.last_of_window = 1'b1;
        expected_samples.push_back(s);
      end
    end
    col_pos = x + 1;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos = y + 1;
      if (row_pos >= hgt) row_pos = 0;
    end
  endtask

  task automatic send_pixel(input pixel_t px);
    if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(14, 1)) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    do @(posedge clk_i); while (!s_axis_tready);
    expand_pixel(px);
  endtask

  task automatic send_pixels(input int unsigned count, input bit pause_ok);
    repeat (count) begin
      if (pause_ok && $urandom_range(49) == 0) begin
        s_axis_tvalid <= 1'b0;
        do @(posedge clk_i); while (expected_samples.size() != 0);
      end
      send_pixel(rand_pixel());
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (expected_samples.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [48:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (index)
      CFG_IMAGE_WIDTH:     reg_width  = value[10:0];
      CFG_IMAGE_HEIGHT:    reg_height = value[10:0];
      CFG_WINDOW_SIZE:     reg_size   = value[2:0];
      CFG_TAP_MASK:        reg_mask   = value;
      CFG_APPEND_CONSTANT: reg_append = value[0];
      default: ;
    endcase
  endtask

  task automatic set_frame(input logic [10:0] width, input logic [10:0] height,
                           input logic [2:0] size, input logic [48:0] mask,
                           input logic append);
    settle();
    write_reg(CFG_IMAGE_WIDTH, 49'(width));
    write_reg(CFG_IMAGE_HEIGHT, 49'(height));
    write_reg(CFG_WINDOW_SIZE, 49'(size));
    write_reg(CFG_TAP_MASK, mask);
    write_reg(CFG_APPEND_CONSTANT, 49'(append));
    cfg_we_i <= 1'b0;
  endtask

  task automatic test_pixel_extremes();
    pixel_t px;
    gap_pct   = 15;
    stall_pct = 15;
    set_frame(4, 3, 3, '1, 1'b1);
    for (int unsigned i = 0; i < 12; i++) begin
      case (i % 6)
        0: px = '{blue: 8'd0,   green: 8'd0,   red: 8'd0};
        1: px = '{blue: 8'd255, green: 8'd255, red: 8'd255};
        2: px = '{blue: 8'd0,   green: 8'd0,   red: 8'd255};
        3: px = '{blue: 8'd0,   green: 8'd255, red: 8'd0};
        4: px = '{blue: 8'd255, green: 8'd0,   red: 8'd0};
        default: px = '{blue: 8'd0, green: 8'd1, red: 8'd1};
      endcase
      send_pixel(px);
    end
  endtask

  // zero dimensions act as one, then a window with nothing selected
  task automatic test_degenerate_config();
    set_frame(0, 0, 0, rand_mask() | 49'd1, 1'b1);
    send_pixels(3, 1'b0);
    set_frame(1, 1, 1, '0, 1'b0);
    send_pixels(2, 1'b0);
  endtask

  task automatic test_frame_below_window();
    set_frame(3, 2, 5, '1, 1'b1);
    send_pixels(6, 1'b0);
  endtask

  // shrink width mid row, then height below the current row
  task automatic test_position_wrap();
    logic [48:0] mask;
    mask = rand_mask() | 49'd1;
    set_frame(4, 4, 3, mask, 1'b1);
    send_pixels(11, 1'b0);
    set_frame(3, 4, 3, mask, 1'b1);
    send_pixels(3, 1'b0);
    set_frame(3, 3, 3, mask, 1'b1);
    send_pixels(9, 1'b0);
  endtask

  task automatic test_random_frames();
    int unsigned sent, sz, w, hgt;
    logic [2:0]  size_raw;
    logic [48:0] mask;
    sent = 0;
    while (sent < RANDOM_PIXELS) begin
      size_raw = 3'($urandom_range(7));
      sz = clamp_dim(size_raw, MAX_SIZE);
      w   = ($urandom_range(9) == 0) ? $urandom_range(sz) : sz + $urandom_range(8);
      hgt = ($urandom_range(9) == 0) ? $urandom_range(sz) : sz + $urandom_range(4);
      case ($urandom_range(5))
        0: mask = '1;
        1: mask = '0;
        2: mask = 49'd1 << $urandom_range(48);
        default: mask = rand_mask();
      endcase
      set_frame(11'(w), 11'(hgt), size_raw, mask, 1'($urandom_range(1)));
      gap_pct   = pick_idle_pct();
      stall_pct = pick_idle_pct();
      w   = clamp_dim(w, MAX_WIDTH);
      hgt = clamp_dim(hgt, MAX_HEIGHT);
      send_pixels(w * hgt, 1'b1);
      sent += w * hgt;
    end
  endtask

  // oversized width register on the first row of a frame
  task automatic test_width_limit();
    gap_pct   = 0;
    stall_pct = 0;
    set_frame(11'h7FF, 2, 1, 49'd1, 1'b0);
    send_pixels(24, 1'b0);
  endtask

  // oversized height register over several rows of a narrow frame
  task automatic test_height_limit();
    gap_pct   = 0;
    stall_pct = 0;
    set_frame(3, 11'h7FF, 2, 49'hF, 1'b1);
    send_pixels(24, 1'b0);
  endtask

  always @(posedge clk_i) begin
    if (stall_left == 0 && stall_pct != 0 && $urandom_range(99) < stall_pct)
      stall_left = $urandom_range(14, 1);
    if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_samples.size() == 0) begin
        $error("beat with no expected sample, tdata %h", m_axis_tdata);
        mismatches++;
      end else begin
        head = expected_samples.pop_front();
        if (m_axis_tdata[15:0] !== head.sample_value) begin
          $error("sample_value expected %0d actual %0d", head.sample_value, m_axis_tdata[15:0]);
          mismatches++;
        end
        if (m_axis_tdata[21:16] !== head.column_index) begin
          $error("column_index expected %0d actual %0d", head.column_index,
                 m_axis_tdata[21:16]);
          mismatches++;
        end
        if (m_axis_tuser !== head.is_constant) begin
          $error("is_constant expected %0d actual %0d", head.is_constant, m_axis_tuser);
          mismatches++;
        end
        if (m_axis_tlast !== head.last_of_window) begin
          $error("last_of_window expected %0d actual %0d", head.last_of_window, m_axis_tlast);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we_i) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("testbench: errors");
        $finish;
      end
    end
  end

  initial begin
    reg_width  = 11'd640;
    reg_height = 11'd480;
    reg_size   = 3'd3;
    reg_mask   = 49'd511;
    reg_append = 1'b1;
    col_pos    = 0;
    row_pos    = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_pixel_extremes();
    test_degenerate_config();
    test_frame_below_window();
    test_position_wrap();
    test_random_frames();
    test_width_limit();
    test_height_limit();
    settle();
    if (mismatches == 0) begin
      $display("testbench: clean");
    end else begin
      $display("testbench: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
rtl/mwpe_pkg.sv
rtl/mwpe_ram.sv
rtl/mwpe_front.sv
rtl/mwpe_queue.sv
rtl/mwpe_back.sv
rtl/masked_window_patch_expander.sv
dv/testbench.sv
